@@ rtl/dpfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Disc player front panel package
// Shared types, codes and constants of the front panel transport controller.
// ----------------------------------------------------------------------------
package dpfp_pkg;

  // Transport modes.
  typedef enum logic [1:0] {
    MODE_PLAY  = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_e;

  // LED selection.
  typedef enum logic [2:0] {
    LED_NO_DISC     = 3'd0,
    LED_PLAYING     = 3'd1,
    LED_STOPPED     = 3'd2,
    LED_PAUSE_SHOWN = 3'd3,
    LED_PAUSE_BLANK = 3'd4
  } led_e;

  // Display modes.
  typedef enum logic [1:0] {
    DISP_COUNT = 2'd0,
    DISP_TRACK = 2'd1,
    DISP_BLANK = 2'd2,
    DISP_TENS  = 2'd3
  } disp_e;

  // Button codes.
  localparam logic [2:0] BTN_NEXT  = 3'd2;
  localparam logic [2:0] BTN_PREV  = 3'd3;
  localparam logic [2:0] BTN_STOP  = 3'd4;
  localparam logic [2:0] BTN_PAUSE = 3'd5;
  localparam logic [2:0] BTN_PLAY  = 3'd6;

  // Ladder key codes: 1 to 10 pick a track.
  localparam int unsigned KEY_W = 4;
  localparam logic [KEY_W-1:0] KEY_NONE      = 4'd0;
  localparam logic [KEY_W-1:0] KEY_TRACK_MIN = 4'd1;
  localparam logic [KEY_W-1:0] KEY_TRACK_MAX = 4'd10;
  localparam logic [KEY_W-1:0] KEY_PLUS_TEN  = 4'd11;

  // Ladder window bounds; a value on a bound is no key.
  localparam int unsigned LVL_W = 10;
  localparam int unsigned NUM_WINDOWS = 11;
  localparam logic [LVL_W-1:0] KEY_BOUNDS [NUM_WINDOWS+1] = '{
    10'd0, 10'd50, 10'd142, 10'd234, 10'd326, 10'd418,
    10'd521, 10'd613, 10'd705, 10'd797, 10'd889, 10'd982
  };
  localparam logic [LVL_W-1:0] PICK_LIMIT = 10'd889;

  // Configuration registers.
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SHOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TENS_TIMEOUT = 2'd2;
  localparam logic [CFG_W-1:0] BLINK_SHOW_RST   = 8'd30;
  localparam logic [CFG_W-1:0] BLINK_PERIOD_RST = 8'd90;
  localparam logic [CFG_W-1:0] TENS_TIMEOUT_RST = 8'd244;

  // Depth of the queue between classifier and executor.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified item.
  typedef struct packed {
    logic             is_tick;
    logic             btn_next;
    logic             btn_prev;
    logic             btn_stop;
    logic             btn_play;
    logic             btn_pause;
    logic [KEY_W-1:0] key;
    logic             pick;
    logic             disc_ready;
    logic             track_end;
    logic             disc_end;
  } item_t;

  // Decode a ladder level into a key code.
  function automatic logic [KEY_W-1:0] ladder_key(input logic [LVL_W-1:0] lvl);
    logic [KEY_W-1:0] key;
    key = KEY_NONE;
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      if (lvl > KEY_BOUNDS[i] && lvl < KEY_BOUNDS[i+1]) begin
        key = KEY_W'(i + 1);
      end
    end
    return key;
  endfunction

endpackage

@@ rtl/dpfp_in_if.sv @@
// ----------------------------------------------------------------------------
// Front panel input channel
// Valid/ready channel that carries poll and tick items.
// ----------------------------------------------------------------------------
interface dpfp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] button_code;
  logic [9:0] key_level;
  logic       disc_ready;
  logic       track_end;
  logic       disc_end;

  modport source (
    output valid, command, button_code, key_level, disc_ready, track_end, disc_end,
    input  ready
  );
  modport sink (
    input  valid, command, button_code, key_level, disc_ready, track_end, disc_end,
    output ready
  );
endinterface

@@ rtl/dpfp_out_if.sv @@
// ----------------------------------------------------------------------------
// Front panel result channel
// Valid/ready channel that carries LED, display and mode results.
// ----------------------------------------------------------------------------
interface dpfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] led_index;
  logic [1:0] display_mode;
  logic [7:0] display_value;
  logic [1:0] play_mode;

  modport source (
    output valid, led_index, display_mode, display_value, play_mode,
    input  ready
  );
  modport sink (
    input  valid, led_index, display_mode, display_value, play_mode,
    output ready
  );
endinterface

@@ rtl/dpfp_front.sv @@
// ----------------------------------------------------------------------------
// Front panel item classifier
// Accepts input transfers and decodes buttons and the key ladder level.
// ----------------------------------------------------------------------------
module dpfp_front (
  dpfp_in_if.sink          in_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output dpfp_pkg::item_t  q_item_o
);

  // Accept whenever the queue has room.
  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;

  // Classify the payload.
  always_comb begin
    q_item_o.is_tick    = in_i.command;
    q_item_o.btn_next   = (in_i.button_code == dpfp_pkg::BTN_NEXT);
    q_item_o.btn_prev   = (in_i.button_code == dpfp_pkg::BTN_PREV);
    q_item_o.btn_stop   = (in_i.button_code == dpfp_pkg::BTN_STOP);
    q_item_o.btn_play   = (in_i.button_code == dpfp_pkg::BTN_PLAY);
    q_item_o.btn_pause  = (in_i.button_code == dpfp_pkg::BTN_PAUSE);
    q_item_o.key        = dpfp_pkg::ladder_key(in_i.key_level);
    q_item_o.pick       = (in_i.key_level != '0) && (in_i.key_level < dpfp_pkg::PICK_LIMIT);
    q_item_o.disc_ready = in_i.disc_ready;
    q_item_o.track_end  = in_i.track_end;
    q_item_o.disc_end   = in_i.disc_end;
  end

endmodule

@@ rtl/dpfp_queue.sv @@
// ----------------------------------------------------------------------------
// Front panel item queue
// Short FIFO of classified items between classifier and executor.
// ----------------------------------------------------------------------------
module dpfp_queue #(
  parameter int unsigned Depth = dpfp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dpfp_pkg::item_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dpfp_pkg::item_t  item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  dpfp_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage; needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue fill count exceeds depth");

  // Nothing is written into a full queue unless an entry leaves at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i && full_o |-> pop_i)
    else $error("queue overflow");

endmodule

@@ rtl/dpfp_back.sv @@
// ----------------------------------------------------------------------------
// Front panel transport executor
// Applies queued items to the transport state and registers each result.
// ----------------------------------------------------------------------------
module dpfp_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [dpfp_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [dpfp_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  logic                                    q_valid_i,
  input  dpfp_pkg::item_t                         q_item_i,
  output logic                                    q_pop_o,
  dpfp_out_if.source                              out_o
);

  // Configuration registers.
  logic [7:0] blink_show_q, blink_period_q, tens_timeout_q;

  // Transport state.
  logic            disc_loaded_q, disc_loaded_d;
  dpfp_pkg::mode_e mode_q, mode_d;
  logic            blank_phase_q, blank_phase_d;
  logic [7:0]      blink_count_q, blink_count_d;
  logic            tens_pending_q, tens_pending_d;
  logic [7:0]      tens_count_q, tens_count_d;
  logic [7:0]      tens_digit_q, tens_digit_d;
  logic [7:0]      track_q, track_d;
  logic [7:0]      track_total_q, track_total_d;
  logic            total_scanned_q, total_scanned_d;
  logic            prev_te_q, prev_te_d;

  // Result register.
  logic              out_valid_q;
  dpfp_pkg::led_e    out_led_q, out_led_d;
  dpfp_pkg::disp_e   out_disp_q, out_disp_d;
  logic [7:0]        out_value_q, out_value_d;
  dpfp_pkg::mode_e   out_mode_q;

  logic take;
  logic te_rise;
  logic picked;
  logic key_track;
  logic active;

  // Take the next item when the result register is free or being drained.
  assign take    = q_valid_i && (!out_valid_q || out_o.ready);
  assign q_pop_o = take;

  assign out_o.valid         = out_valid_q;
  assign out_o.led_index     = out_led_q;
  assign out_o.display_mode  = out_disp_q;
  assign out_o.display_value = out_value_q;
  assign out_o.play_mode     = out_mode_q;

  assign te_rise   = q_item_i.track_end && !prev_te_q;
  assign key_track = (q_item_i.key >= dpfp_pkg::KEY_TRACK_MIN) &&
                     (q_item_i.key <= dpfp_pkg::KEY_TRACK_MAX);
  assign active    = (mode_q == dpfp_pkg::MODE_PLAY) || (mode_q == dpfp_pkg::MODE_PAUSE);

  // Next transport state for the item at the head of the queue.
  always_comb begin
    disc_loaded_d   = disc_loaded_q;
    mode_d          = mode_q;
    blank_phase_d   = blank_phase_q;
    blink_count_d   = blink_count_q;
    tens_pending_d  = tens_pending_q;
    tens_count_d    = tens_count_q;
    tens_digit_d    = tens_digit_q;
    track_d         = track_q;
    track_total_d   = track_total_q;
    total_scanned_d = total_scanned_q;
    prev_te_d       = prev_te_q;
    picked          = 1'b0;

    if (q_item_i.is_tick) begin
      // Pause blink timer.
      if (mode_q == dpfp_pkg::MODE_PAUSE) begin
        if (!blank_phase_q) begin
          if (blink_count_q < blink_show_q) begin
            blink_count_d = blink_count_q + 8'd1;
          end else if (blink_count_q == blink_show_q) begin
            blank_phase_d = 1'b1;
          end
        end else begin
          if (blink_count_q < blink_period_q) begin
            blink_count_d = blink_count_q + 8'd1;
          end else if (blink_count_q == blink_period_q) begin
            blink_count_d = '0;
            blank_phase_d = 1'b0;
          end
        end
      end
      // Plus-ten timeout.
      if (tens_pending_q) begin
        if (tens_count_q < tens_timeout_q) begin
          tens_count_d = tens_count_q + 8'd1;
        end else begin
          tens_digit_d   = '0;
          tens_count_d   = '0;
          tens_pending_d = 1'b0;
        end
      end
    end else begin
      prev_te_d = q_item_i.track_end;
      if (!disc_loaded_q) begin
        // Track scan of a newly inserted disc.
        if (q_item_i.disc_ready) begin
          track_d = 8'd1;
          if (!total_scanned_q) begin
            if (te_rise) begin
              track_total_d = track_total_q + 8'd1;
            end else if (q_item_i.disc_end) begin
              track_total_d = track_total_q + 8'd1;
              mode_d        = dpfp_pkg::MODE_STOP;
              disc_loaded_d = 1'b1;
            end
          end else begin
            mode_d = dpfp_pkg::MODE_STOP;
          end
        end
      end else begin
        total_scanned_d = 1'b1;
        // Ladder keys with the plus-ten prefix.
        if (active) begin
          if (q_item_i.key == dpfp_pkg::KEY_PLUS_TEN) begin
            tens_digit_d   = tens_digit_q + 8'd1;
            tens_pending_d = 1'b1;
          end
          if (tens_pending_d) begin
            if (q_item_i.pick) begin
              picked = 1'b1;
              if (key_track) begin
                track_d = 8'(q_item_i.key) + {tens_digit_d[4:0], 3'b000}
                        + {tens_digit_d[6:0], 1'b0};
              end
            end
          end else if (key_track) begin
            track_d = 8'(q_item_i.key);
          end
        end
        if (!q_item_i.disc_ready) begin
          track_d       = '0;
          disc_loaded_d = 1'b0;
        end

        // Track stepping with wrap to stop.
        if ((q_item_i.btn_next && track_d == track_total_q) ||
            (q_item_i.btn_prev && track_d == 8'd1)) begin
          track_d = 8'd1;
          mode_d  = dpfp_pkg::MODE_STOP;
        end else if (q_item_i.btn_next) begin
          track_d = track_d + 8'd1;
        end else if (q_item_i.btn_prev && track_d > 8'd1) begin
          track_d = track_d - 8'd1;
        end else if (te_rise && !q_item_i.disc_end) begin
          track_d = track_d + 8'd1;
        end

        // Mode transitions, taken from the mode after stepping.
        unique case (mode_d)
          dpfp_pkg::MODE_PLAY: begin
            if (q_item_i.btn_stop || (q_item_i.track_end && q_item_i.disc_end)) begin
              track_d = 8'd1;
              mode_d  = dpfp_pkg::MODE_STOP;
            end else if (q_item_i.btn_pause) begin
              blank_phase_d = 1'b0;
              mode_d        = dpfp_pkg::MODE_PAUSE;
            end
          end
          dpfp_pkg::MODE_STOP: begin
            track_d = 8'd1;
            if (q_item_i.btn_play || q_item_i.btn_next || q_item_i.btn_prev) begin
              mode_d = dpfp_pkg::MODE_PLAY;
            end
          end
          dpfp_pkg::MODE_PAUSE: begin
            if (q_item_i.btn_stop) begin
              track_d = 8'd1;
              mode_d  = dpfp_pkg::MODE_STOP;
            end else if (q_item_i.btn_play || q_item_i.btn_pause) begin
              mode_d = dpfp_pkg::MODE_PLAY;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result from the updated state.
  always_comb begin
    if (!disc_loaded_d) begin
      out_led_d   = dpfp_pkg::LED_NO_DISC;
      out_disp_d  = dpfp_pkg::DISP_COUNT;
      out_value_d = track_total_d;
    end else begin
      unique case (mode_d)
        dpfp_pkg::MODE_PLAY:  out_led_d = dpfp_pkg::LED_PLAYING;
        dpfp_pkg::MODE_PAUSE: out_led_d = blank_phase_d ? dpfp_pkg::LED_PAUSE_BLANK
                                                        : dpfp_pkg::LED_PAUSE_SHOWN;
        default:              out_led_d = dpfp_pkg::LED_STOPPED;
      endcase
      if ((mode_d == dpfp_pkg::MODE_PLAY || mode_d == dpfp_pkg::MODE_PAUSE) &&
          tens_pending_d && !picked) begin
        out_disp_d  = dpfp_pkg::DISP_TENS;
        out_value_d = tens_digit_d;
      end else if (mode_d == dpfp_pkg::MODE_PAUSE && blank_phase_d) begin
        out_disp_d  = dpfp_pkg::DISP_BLANK;
        out_value_d = '0;
      end else begin
        out_disp_d  = dpfp_pkg::DISP_TRACK;
        out_value_d = track_d;
      end
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_show_q   <= dpfp_pkg::BLINK_SHOW_RST;
      blink_period_q <= dpfp_pkg::BLINK_PERIOD_RST;
      tens_timeout_q <= dpfp_pkg::TENS_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpfp_pkg::CFG_BLINK_SHOW:   blink_show_q   <= cfg_wdata_i;
        dpfp_pkg::CFG_BLINK_PERIOD: blink_period_q <= cfg_wdata_i;
        dpfp_pkg::CFG_TENS_TIMEOUT: tens_timeout_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Transport state registers advance on each taken item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_loaded_q   <= 1'b0;
      mode_q          <= dpfp_pkg::MODE_STOP;
      blank_phase_q   <= 1'b0;
      blink_count_q   <= '0;
      tens_pending_q  <= 1'b0;
      tens_count_q    <= '0;
      tens_digit_q    <= '0;
      track_q         <= '0;
      track_total_q   <= '0;
      total_scanned_q <= 1'b0;
      prev_te_q       <= 1'b0;
    end else if (take) begin
      disc_loaded_q   <= disc_loaded_d;
      mode_q          <= mode_d;
      blank_phase_q   <= blank_phase_d;
      blink_count_q   <= blink_count_d;
      tens_pending_q  <= tens_pending_d;
      tens_count_q    <= tens_count_d;
      tens_digit_q    <= tens_digit_d;
      track_q         <= track_d;
      track_total_q   <= track_total_d;
      total_scanned_q <= total_scanned_d;
      prev_te_q       <= prev_te_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_led_q   <= out_led_d;
      out_disp_q  <= out_disp_d;
      out_value_q <= out_value_d;
      out_mode_q  <= mode_d;
    end
  end

  // Without a pending prefix the prefix timer and digit rest at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tens_pending_q |-> (tens_count_q == '0) && (tens_digit_q == '0))
    else $error("plus-ten state left over without a pending prefix");

  // The no-disc LED always comes with the track count display.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_led_q == dpfp_pkg::LED_NO_DISC) |-> (out_disp_q == dpfp_pkg::DISP_COUNT))
    else $error("no-disc result without track count display");

  // A blank display shows zero and only happens while paused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_disp_q == dpfp_pkg::DISP_BLANK) |->
      (out_value_q == '0) && (out_mode_q == dpfp_pkg::MODE_PAUSE) &&
      (out_led_q == dpfp_pkg::LED_PAUSE_BLANK))
    else $error("blank display outside the pause blank phase");

  // The playing LED matches the reported mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_led_q == dpfp_pkg::LED_PLAYING) |-> (out_mode_q == dpfp_pkg::MODE_PLAY))
    else $error("playing LED with another mode");

endmodule

@@ rtl/disc_player_front_panel_control.sv @@
// ----------------------------------------------------------------------------
// Disc player front panel transport controller
// Top level: classifier, item queue and transport executor.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the in_i channel: a poll (command 0) carries the button
// code, the 10-bit key ladder level and the disc status lines; a tick
// (command 1) advances the pause blink and plus-ten timers. Every item
// yields exactly one result transfer on out_o with the LED, the display
// mode and value, and the play mode.
// An item is written first into the queue and then into the executor's result
// register. Throughput is one item per cycle while out_o takes each result.
// When out_o stalls, the result register holds, the queue of Depth entries
// fills, and in_i.ready falls only once it is full. Reset empties the queue
// and the result register and returns all state and configuration registers
// to their reset values. Configuration must be written by the user through
// cfg_we_i, cfg_idx_i and cfg_wdata_i while no item is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module disc_player_front_panel_control #(
  parameter int unsigned Depth = dpfp_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpfp_pkg::CFG_W-1:0]      cfg_wdata_i,
  dpfp_in_if.sink                         in_i,
  dpfp_out_if.source                      out_o
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  dpfp_pkg::item_t push_item;
  dpfp_pkg::item_t head_item;

  // Classifier.
  dpfp_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (push_item)
  );

  // Queue between classifier and executor.
  dpfp_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // Executor.
  dpfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule
